FILE: sv/sawt_pkg.sv
// ----------------------------------------------------------------------------
// sawt_pkg
// Shared types and constants for the selective ack window tracker.
// ----------------------------------------------------------------------------
package sawt_pkg;

  // Event codes carried in func
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_RECV = 2'd1;
  localparam logic [1:0] FUNC_ACK  = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SENT   = 2'd1;
  localparam logic [1:0] KIND_ACKED  = 2'd2;
  localparam logic [1:0] KIND_LOST   = 2'd3;

  // Register indexes
  localparam logic [0:0] REG_MAX_SEQ = 1'd0;
  localparam logic [0:0] REG_TIMEOUT = 1'd1;

  localparam logic [31:0] MAX_SEQ_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam int          WINDOW_BITS   = 32;
  localparam logic [23:0] RTT_MAX       = 24'hFF_FFFF;
  localparam logic [7:0]  RTT_GAIN      = 8'd26;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] sequence_req;
    logic [31:0] ack_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] out_sequence;
    logic [31:0] out_remote_sequence;
    logic [31:0] out_ack_mask;
    logic [23:0] out_rtt;
    logic [31:0] out_lost_total;
    logic [31:0] out_acked_total;
    logic        out_last;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_RECV_RED, OP_RECV, OP_SEND_DROP, OP_SEND_PUSH,
    OP_ACK_RED, OP_ACK_TEST, OP_ACK_RTT, OP_ACK_REMOVE, OP_TICK, OP_TICK_DROP,
    OP_SHIFT, OP_STATUS
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [5:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] count;
    logic       hit;
    logic       expired;
    logic       reduce_busy;
  } dp_stat_t;

  // x mod (m+1) by repeated subtraction is avoided: the restoring reducer
  // unit needs one step per bit of x, whatever m is (see datapath).
endpackage

FILE: sv/sawt_ctrl.sv
// ----------------------------------------------------------------------------
// sawt_ctrl
// Sequencer: walks each event through datapath steps and removal shifts.
// ----------------------------------------------------------------------------
module sawt_ctrl
  import sawt_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     emit_wait,
  input  logic     out_free
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RECV_RED, S_RECV, S_SEND, S_PUSH, S_ACK_RED, S_ACK_TEST,
    S_ACK_RTT, S_ACK_REM, S_TICK_TEST, S_TICK_DROP, S_SHIFT, S_STATUS
  } state_t;

  localparam int IW = $clog2(DEPTH + 1);

  state_t     state, ret_state;
  logic [5:0] idx, shift_idx;

  assign busy = (state != S_IDLE);
  // result-producing states need the output register free
  assign emit_wait = !out_free &&
    (state == S_SEND || state == S_PUSH || state == S_ACK_REM ||
     state == S_TICK_DROP || state == S_STATUS);

  // command decode
  always_comb begin
    cmd.idx = idx;
    cmd.op  = OP_NONE;
    unique case (state)
      S_IDLE:      cmd.op = in_fire ? OP_LATCH : OP_NONE;
      S_DISPATCH:  cmd.op = OP_NONE;
      S_RECV_RED:  cmd.op = OP_RECV_RED;
      S_RECV:      cmd.op = stat.reduce_busy ? OP_NONE : OP_RECV;
      S_SEND:      cmd.op = (out_free && stat.count >= 6'(DEPTH)) ? OP_SEND_DROP : OP_NONE;
      S_PUSH:      cmd.op = out_free ? OP_SEND_PUSH : OP_NONE;
      S_ACK_RED:   cmd.op = OP_ACK_RED;
      S_ACK_TEST:  cmd.op = stat.reduce_busy ? OP_NONE : OP_ACK_TEST;
      S_ACK_RTT:   cmd.op = OP_ACK_RTT;
      S_ACK_REM:   cmd.op = out_free ? OP_ACK_REMOVE : OP_NONE;
      S_TICK_TEST: cmd.op = OP_TICK;
      S_TICK_DROP: cmd.op = out_free ? OP_TICK_DROP : OP_NONE;
      S_SHIFT:     begin cmd.op = OP_SHIFT; cmd.idx = shift_idx; end
      S_STATUS:    cmd.op = out_free ? OP_STATUS : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_state <= S_IDLE;
      idx <= '0;
      shift_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_DISPATCH;
        S_DISPATCH: begin
          idx <= '0;
          unique case (stat.func)
            FUNC_SEND: state <= S_SEND;
            FUNC_RECV: state <= S_RECV_RED;
            FUNC_ACK:  state <= S_ACK_RED;
            default:   state <= S_TICK_TEST;
          endcase
        end
        S_RECV_RED: state <= S_RECV;
        S_RECV: if (!stat.reduce_busy) state <= S_STATUS;
        S_SEND: if (out_free || stat.count < 6'(DEPTH)) begin
          if (stat.count >= 6'(DEPTH)) begin
            shift_idx <= '0;
            ret_state <= S_PUSH;
            state <= S_SHIFT;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: if (out_free) state <= S_STATUS;
        S_ACK_RED: state <= S_ACK_TEST;
        S_ACK_TEST: if (!stat.reduce_busy) begin
          if (idx >= stat.count) state <= S_STATUS;
          else state <= S_ACK_RTT;
        end
        S_ACK_RTT: begin
          if (stat.hit) state <= S_ACK_REM;
          else begin
            idx <= idx + 6'd1;
            state <= S_ACK_RED;
          end
        end
        S_ACK_REM: if (out_free) begin
          shift_idx <= idx;
          ret_state <= S_ACK_RED;
          state <= S_SHIFT;
        end
        S_TICK_TEST: state <= stat.expired ? S_TICK_DROP : S_STATUS;
        S_TICK_DROP: if (out_free) begin
          shift_idx <= '0;
          ret_state <= S_TICK_TEST;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // count already decremented at removal
          if (IW'(shift_idx) + IW'(1) >= IW'(stat.count) + IW'(1)) state <= ret_state;
          else shift_idx <= shift_idx + 6'd1;
        end
        S_STATUS: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !emit_wait) else $error("emit wait while idle");
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> shift_idx < 6'(DEPTH)) else $error("shift index out of range");
  a_ack_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_ACK_RTT |-> idx < stat.count) else $error("ack scan past count");
endmodule

FILE: sv/sawt_dp.sv
// ----------------------------------------------------------------------------
// sawt_dp
// Datapath: sequence state, pending queue registers, window, rtt, counters.
// ----------------------------------------------------------------------------
module sawt_dp
  import sawt_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_item,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [31:0] max_sequence,
  input  logic [15:0] timeout_ticks,
  output logic        emit,
  output out_item_t   emit_item
);
  localparam int AW = $clog2(DEPTH);

  logic [1:0]  func;
  logic [31:0] req_seq, req_mask;
  logic [31:0] next_local, newest_remote, window, cur_tick, lost_cnt, acked_cnt;
  logic [23:0] rtt;
  logic [5:0]  count;
  logic [31:0] pend_seq  [DEPTH];
  logic [31:0] pend_tick [DEPTH];

  // serial reducer: x mod (m+1), restoring, one bit per cycle
  logic [32:0] red_rem, red_m1;
  logic [31:0] red_x;
  logic [5:0]  red_cnt;
  logic        red_busy;
  logic [31:0] red_a;        // reduced stored newest or pending entry sequence
  logic        red_second;   // second reduction pending
  logic [31:0] red_first;
  logic [32:0] red_trial;

  // receive/ack comparison values
  logic [31:0] s_val, r_val, half;
  logic        newer_sr, newer_as;
  logic [32:0] idx_sr, idx_as;
  logic [AW-1:0] ci;

  assign ci = cmd.idx[AW-1:0];
  assign half = max_sequence >> 1;
  assign red_trial = {red_rem[31:0], red_x[31]};
  // second reduction result stays in the remainder until the next pass
  assign red_a = red_rem[31:0];

  function automatic logic newer(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] h);
    newer = (a > b && (a - b) <= h) || (b > a && (b - a) > h);
  endfunction

  // index of older s relative to reference r
  function automatic logic [32:0] widx(input logic [31:0] s, input logic [31:0] r,
                                      input logic [31:0] m);
    if (s > r) widx = {1'b0, r} + {1'b0, m} - {1'b0, s};
    else       widx = {1'b0, r} - 33'd1 - {1'b0, s};
  endfunction

  // receive: s = red_first (incoming), r = red_a (stored newest)
  assign s_val = red_first;
  assign r_val = red_a;
  assign newer_sr = newer(s_val, r_val, half);
  assign idx_sr = newer_sr ? widx(r_val, s_val, max_sequence) + 33'd1
                           : widx(s_val, r_val, max_sequence);
  // ack: entry s = red_a, ack a = red_first
  assign newer_as = newer(red_a, red_first, half);
  assign idx_as = widx(red_a, red_first, max_sequence);

  // rtt pipeline
  logic [31:0] age;
  logic signed [41:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] delta;
  logic signed [50:0] rtt_sum;
  logic [23:0] rtt_new;
  logic hit, expired;
  logic signed [41:0] diff_q;

  assign age  = cur_tick - pend_tick[ci];
  assign diff = $signed({2'b0, age, 8'b0}) - $signed({18'b0, rtt});
  assign prod = diff_q * $signed({1'b0, RTT_GAIN});
  // floor division by 256 (arithmetic shift)
  assign delta = prod >>> 8;
  assign rtt_sum = $signed({27'b0, rtt}) + 51'(delta);
  assign rtt_new = rtt_sum < 0 ? 24'd0 :
                   (rtt_sum > $signed({27'b0, RTT_MAX}) ? RTT_MAX : rtt_sum[23:0]);

  // oldest entry timed out; the first test of a tick counts the new tick
  assign expired = (count != 6'd0) &&
                   ((cur_tick + (hit ? 32'd0 : 32'd1) - pend_tick[0]) >
                    {16'd0, timeout_ticks});

  assign stat.func = func;
  assign stat.count = count;
  assign stat.hit = hit;
  assign stat.expired = expired;
  assign stat.reduce_busy = red_busy || red_second;

  assign emit = (cmd.op == OP_SEND_DROP) || (cmd.op == OP_SEND_PUSH) ||
                (cmd.op == OP_ACK_REMOVE) || (cmd.op == OP_TICK_DROP) ||
                (cmd.op == OP_STATUS);

  logic [31:0] next_inc;
  assign next_inc = next_local + 32'd1;

  // result composition reflects state after the event's update
  always_comb begin
    emit_item.out_remote_sequence = newest_remote;
    emit_item.out_ack_mask = window;
    emit_item.out_rtt = rtt;
    emit_item.out_lost_total = lost_cnt;
    emit_item.out_acked_total = acked_cnt;
    emit_item.out_last = 1'b0;
    emit_item.out_kind = KIND_STATUS;
    emit_item.out_sequence = next_local;
    case (cmd.op)
      OP_SEND_DROP: begin
        emit_item.out_kind = KIND_LOST;
        emit_item.out_sequence = pend_seq[0];
        emit_item.out_lost_total = lost_cnt + 32'd1;
      end
      OP_SEND_PUSH: begin
        emit_item.out_kind = KIND_SENT;
        emit_item.out_sequence = next_local;
      end
      OP_ACK_REMOVE: begin
        emit_item.out_kind = KIND_ACKED;
        emit_item.out_sequence = pend_seq[ci];
        emit_item.out_rtt = rtt_new;
        emit_item.out_acked_total = acked_cnt + 32'd1;
      end
      OP_TICK_DROP: begin
        emit_item.out_kind = KIND_LOST;
        emit_item.out_sequence = pend_seq[0];
        emit_item.out_lost_total = lost_cnt + 32'd1;
      end
      OP_STATUS: emit_item.out_last = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      next_local <= '0; newest_remote <= '0; window <= '0; cur_tick <= '0;
      lost_cnt <= '0; acked_cnt <= '0; rtt <= '0; count <= '0;
      red_busy <= 1'b0; red_second <= 1'b0; hit <= 1'b0;
    end else begin
      // reducer step
      if (red_busy) begin
        if (red_trial >= red_m1) red_rem <= red_trial - red_m1;
        else red_rem <= red_trial;
        red_x <= red_x << 1;
        red_cnt <= red_cnt - 6'd1;
        if (red_cnt == 6'd1) begin
          red_busy <= 1'b0;
        end
      end else if (red_second) begin
        red_first <= red_rem[31:0];
        red_x <= red_first;
        red_rem <= '0;
        red_busy <= 1'b1;
        red_second <= 1'b0;
        red_cnt <= 6'd32;
      end

      case (cmd.op)
        OP_LATCH: begin
          func <= in_item.func;
          req_seq <= in_item.sequence_req;
          req_mask <= in_item.ack_mask;
        end
        OP_RECV_RED: begin
          red_m1 <= {1'b0, max_sequence} + 33'd1;
          red_x <= req_seq; red_rem <= '0; red_cnt <= 6'd32;
          red_busy <= 1'b1; red_second <= 1'b1;
          red_first <= newest_remote;
        end
        OP_ACK_RED: begin
          red_m1 <= {1'b0, max_sequence} + 33'd1;
          red_x <= req_seq; red_rem <= '0; red_cnt <= 6'd32;
          red_busy <= 1'b1; red_second <= 1'b1;
          red_first <= pend_seq[ci];
        end
        OP_RECV: begin
          if (s_val != r_val) begin
            if (newer_sr) begin
              window <= ((idx_sr >= 33'd32) ? 32'd0 : (window << idx_sr[4:0])) |
                        ((idx_sr <= 33'd32) ? (32'd1 << 5'(idx_sr - 33'd1)) : 32'd0);
              newest_remote <= s_val;
            end else if (idx_sr <= 33'd31) begin
              window <= window | (32'd1 << idx_sr[4:0]);
            end
          end
        end
        OP_ACK_TEST: begin
          hit <= (red_a == red_first) ||
                 (!newer_as && idx_as <= 33'd31 && req_mask[idx_as[4:0]]);
          diff_q <= diff;
        end
        OP_ACK_RTT: ;
        OP_ACK_REMOVE: begin
          rtt <= rtt_new;
          acked_cnt <= acked_cnt + 32'd1;
          count <= count - 6'd1;
        end
        OP_SEND_DROP: begin
          lost_cnt <= lost_cnt + 32'd1;
          count <= count - 6'd1;
        end
        OP_SEND_PUSH: begin
          pend_seq[count[AW-1:0]] <= next_local;
          pend_tick[count[AW-1:0]] <= cur_tick;
          count <= count + 6'd1;
          next_local <= (next_local == 32'hFFFF_FFFF || next_inc > max_sequence)
                        ? 32'd0 : next_inc;
        end
        OP_TICK: begin
          if (!hit) begin
            cur_tick <= cur_tick + 32'd1;
            hit <= 1'b1;
          end
        end
        OP_TICK_DROP: begin
          lost_cnt <= lost_cnt + 32'd1;
          count <= count - 6'd1;
        end
        OP_SHIFT: begin
          if (int'(ci) + 1 < DEPTH) begin
            pend_seq[ci] <= pend_seq[AW'(int'(ci) + 1)];
            pend_tick[ci] <= pend_tick[AW'(int'(ci) + 1)];
          end
        end
        OP_STATUS: hit <= 1'b0;
        default: ;
      endcase
      if (cmd.op == OP_LATCH) hit <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 6'(DEPTH)) else $error("pending count overflow");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SEND_PUSH |-> count < 6'(DEPTH)) else $error("push into full queue");
  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_TICK_DROP || cmd.op == OP_ACK_REMOVE) |-> count != 6'd0)
    else $error("removal from empty queue");
endmodule

FILE: sv/selective_ack_window_tracker.sv
// ----------------------------------------------------------------------------
// selective_ack_window_tracker
// Reliability tracking for sequenced datagrams with a selective ack window.
// ----------------------------------------------------------------------------
// One transaction at a time: the input stalls from acceptance until the status
// result of that transaction has been issued. Each input transaction yields its
// event results followed by one status result flagged out_last. Sequences are
// reduced modulo max_sequence + 1 by a serial unit. A send drops and shifts out
// the oldest entry when the queue is full, then pushes; a receive reduces the
// incoming and stored sequences and updates the window; an ack reduces and tests
// each pending entry in turn, a removal shifting the entries behind it; a tick
// drops the oldest entry, with a shift, while it has timed out. Steps that issue
// a result wait while the output register is not free. Configuration writes are
// taken at any time and should come while idle.
module selective_ack_window_tracker
  import sawt_pkg::*;
#(
  parameter int PENDING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] max_sequence;
  logic [15:0] timeout_ticks;
  logic        busy, in_fire, emit, emit_wait, out_free;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  out_item_t   emit_item;

  assign pready = 1'b1;
  assign in_stall = busy;
  assign in_fire = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sequence <= MAX_SEQ_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_MAX_SEQ: max_sequence <= pwdata;
        REG_TIMEOUT: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_MAX_SEQ: prdata = max_sequence;
      REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit && out_free) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) if (emit && out_free) out_data <= emit_item;

  sawt_ctrl #(.DEPTH(PENDING_DEPTH)) u_ctrl (
    .clk, .rst, .in_fire, .busy, .stat, .cmd, .emit_wait, .out_free
  );

  sawt_dp #(.DEPTH(PENDING_DEPTH)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .max_sequence, .timeout_ticks,
    .emit, .emit_item
  );

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free) else $error("result issued while output full");
  a_wait_blocks: assert property (@(posedge clk) disable iff (rst)
    emit_wait |-> !emit) else $error("result issued while waiting");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("accept did not start work");
endmodule

FILE: dv/tb_selective_ack_window_tracker.sv
// ----------------------------------------------------------------------------
// tb_selective_ack_window_tracker
// Drives send, receive, ack and tick transactions through the tracker with
// random bursts and output stalls, predicts every result in a local model of
// the pending queue, remote window and round trip average, and compares each
// result field by field. Sequence space and timeout are changed between
// phases through the APB port.
// ----------------------------------------------------------------------------
module tb_selective_ack_window_tracker;
  import sawt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  selective_ack_window_tracker #(.PENDING_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Tracker shadow state
  logic [31:0] seq_limit;
  logic [15:0] timeout_limit;
  logic [31:0] local_seq, remote_seq, remote_window, tick_now;
  logic [31:0] lost_cnt, acked_cnt;
  logic [23:0] rtt_avg;
  logic [31:0] pend_seq[$];
  logic [31:0] pend_tick[$];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  bit        hold_sender = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [32:0] reduce(input logic [31:0] s);
    return {1'b0, s} % ({1'b0, seq_limit} + 33'd1);
  endfunction

  function automatic bit is_newer(input logic [32:0] a, input logic [32:0] b);
    logic [32:0] half;
    half = {1'b0, seq_limit} >> 1;
    return (a > b && a - b <= half) || (b > a && b - a > half);
  endfunction

  function automatic logic [32:0] window_pos(input logic [32:0] s,
                                             input logic [32:0] r);
    if (s > r) return r + {1'b0, seq_limit} - s;
    return r - 33'd1 - s;
  endfunction

  task automatic push_result(input logic [1:0] kind, input logic [31:0] s);
    out_item_t r;
    r.out_kind = kind;
    r.out_sequence = s;
    r.out_remote_sequence = remote_seq;
    r.out_ack_mask = remote_window;
    r.out_rtt = rtt_avg;
    r.out_lost_total = lost_cnt;
    r.out_acked_total = acked_cnt;
    r.out_last = 1'b0;
    expected_results = {expected_results, r};
  endtask

  task automatic fold_rtt(input logic [31:0] age);
    longint diff, prod, delta, nxt;
    diff = longint'({age, 8'h00}) - longint'(rtt_avg);
    prod = diff * 26;
    if (prod < 0) delta = -((-prod + 255) >>> 8);
    else delta = prod >>> 8;
    nxt = longint'(rtt_avg) + delta;
    if (nxt < 0) nxt = 0;
    if (nxt > 64'hFF_FFFF) nxt = 64'hFF_FFFF;
    rtt_avg = nxt[23:0];
  endtask

  // Work out all results of one accepted transaction
  task automatic predict_item(input in_item_t it);
    logic [32:0] s, r, a, d;
    logic [31:0] assigned;
    bit hit;
    int i;
    case (it.func)
      FUNC_SEND: begin
        assigned = local_seq;
        if (pend_seq.size() >= DEPTH) begin
          lost_cnt++;
          push_result(KIND_LOST, pend_seq[0]);
          pend_seq.delete(0);
          pend_tick.delete(0);
        end
        pend_seq = {pend_seq, assigned};
        pend_tick = {pend_tick, tick_now};
        local_seq = assigned + 1;
        if (assigned == 32'hFFFF_FFFF || local_seq > seq_limit) local_seq = 0;
        push_result(KIND_SENT, assigned);
      end
      FUNC_RECV: begin
        s = reduce(it.sequence_req);
        r = reduce(remote_seq);
        if (s != r) begin
          if (is_newer(s, r)) begin
            d = window_pos(r, s) + 1;
            remote_window = (d >= 32) ? '0 : remote_window << d[4:0];
            if (d <= 32) remote_window[d - 1] = 1'b1;
            remote_seq = s[31:0];
          end else begin
            d = window_pos(s, r);
            if (d <= 31) remote_window[d[4:0]] = 1'b1;
          end
        end
      end
      FUNC_ACK: begin
        a = reduce(it.sequence_req);
        i = 0;
        while (i < pend_seq.size()) begin
          s = reduce(pend_seq[i]);
          hit = 1'b0;
          if (s == a) hit = 1'b1;
          else if (!is_newer(s, a)) begin
            d = window_pos(s, a);
            if (d <= 31) hit = it.ack_mask[d[4:0]];
          end
          if (hit) begin
            fold_rtt(tick_now - pend_tick[i]);
            acked_cnt++;
            push_result(KIND_ACKED, pend_seq[i]);
            pend_seq.delete(i);
            pend_tick.delete(i);
          end else begin
            i++;
          end
        end
      end
      default: begin
        tick_now++;
        while (pend_seq.size() > 0 && (tick_now - pend_tick[0]) > timeout_limit) begin
          lost_cnt++;
          push_result(KIND_LOST, pend_seq[0]);
          pend_seq.delete(0);
          pend_tick.delete(0);
        end
      end
    endcase
    push_result(KIND_STATUS, local_seq);
    expected_results[$].out_last = 1'b1;
  endtask

  // Driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold payload
    end else begin
      if (in_valid) begin
        predict_item(in_data);
        pending_items.delete(0);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!hold_sender && pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: alternating quiet and busy stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) out_stall <= 1'b0;
    else if ((stall_phase / 64) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Monitor
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        if (out_data.out_kind !== e.out_kind)
          report_mismatch($sformatf("out_kind %0d exp %0d", out_data.out_kind, e.out_kind));
        if (out_data.out_sequence !== e.out_sequence)
          report_mismatch($sformatf("out_sequence %h exp %h",
                                    out_data.out_sequence, e.out_sequence));
        if (out_data.out_remote_sequence !== e.out_remote_sequence)
          report_mismatch($sformatf("out_remote_sequence %h exp %h",
                                    out_data.out_remote_sequence, e.out_remote_sequence));
        if (out_data.out_ack_mask !== e.out_ack_mask)
          report_mismatch($sformatf("out_ack_mask %h exp %h",
                                    out_data.out_ack_mask, e.out_ack_mask));
        if (out_data.out_rtt !== e.out_rtt)
          report_mismatch($sformatf("out_rtt %h exp %h", out_data.out_rtt, e.out_rtt));
        if (out_data.out_lost_total !== e.out_lost_total)
          report_mismatch($sformatf("out_lost_total %0d exp %0d",
                                    out_data.out_lost_total, e.out_lost_total));
        if (out_data.out_acked_total !== e.out_acked_total)
          report_mismatch($sformatf("out_acked_total %0d exp %0d",
                                    out_data.out_acked_total, e.out_acked_total));
        if (out_data.out_last !== e.out_last)
          report_mismatch($sformatf("out_last %b exp %b", out_data.out_last, e.out_last));
      end
    end
  end

  task automatic add_item(input logic [1:0] f, input logic [31:0] s,
                          input logic [31:0] m);
    in_item_t it;
    it.func = f;
    it.sequence_req = s;
    it.ack_mask = m;
    pending_items = {pending_items, it};
  endtask

  // Wait for the block to drain completely
  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_MAX_SEQ) seq_limit = v;
    else timeout_limit = v[15:0];
    @(posedge clk);
  endtask

  // Random traffic: mostly send/ack exchanges near the live window
  task automatic random_items(input int n);
    int k, sel;
    logic [31:0] base;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      base = local_seq - $urandom_range(0, 40);
      if (sel < 35) add_item(FUNC_SEND, $urandom, $urandom);
      else if (sel < 55) add_item(FUNC_RECV,
          ($urandom_range(0, 4) == 0) ? $urandom : base, $urandom);
      else if (sel < 80) add_item(FUNC_ACK,
          ($urandom_range(0, 5) == 0) ? $urandom : base,
          ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      else add_item(FUNC_TICK, $urandom, $urandom);
    end
  endtask

  initial begin
    int k;
    seq_limit = MAX_SEQ_RESET;
    timeout_limit = TIMEOUT_RESET;
    local_seq = 0; remote_seq = 0; remote_window = 0; tick_now = 0;
    lost_cnt = 0; acked_cnt = 0; rtt_avg = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small sequence space, short timeout
    apb_write(REG_MAX_SEQ, 32'd63);
    apb_write(REG_TIMEOUT, 16'd1);
    add_item(FUNC_RECV, 32'd0, 32'd0);
    add_item(FUNC_RECV, 32'd5, 32'd0);
    add_item(FUNC_RECV, 32'd3, 32'd0);
    add_item(FUNC_RECV, 32'd50, 32'd0);
    add_item(FUNC_RECV, 32'hFFFF_FFFF, 32'd0);
    add_item(FUNC_RECV, 32'd20, 32'd0);
    for (k = 0; k < 34; k++) add_item(FUNC_SEND, 32'd0, 32'd0);
    add_item(FUNC_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(FUNC_ACK, 32'd40, 32'hFFFF_FFFF);
    add_item(FUNC_ACK, 32'hFFFF_FFFF, 32'h0000_0001);
    add_item(FUNC_TICK, 32'd0, 32'd0);
    add_item(FUNC_TICK, 32'd0, 32'd0);
    add_item(FUNC_TICK, 32'd0, 32'd0);
    wait_drained();

    // Largest sequence space, longest timeout
    apb_write(REG_MAX_SEQ, 32'hFFFF_FFFF);
    apb_write(REG_TIMEOUT, 16'hFFFF);
    random_items(15);
    // Hold the sender until everything has come back
    while (pending_items.size() > 0) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_results.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    random_items(5);
    wait_drained();

    apb_write(REG_MAX_SEQ, 32'd100 + $urandom_range(0, 200));
    apb_write(REG_TIMEOUT, $urandom_range(2, 12));
    random_items(20);
    wait_drained();

    apb_write(REG_MAX_SEQ, 32'd63);
    apb_write(REG_TIMEOUT, 16'd3);
    random_items(15);
    wait_drained();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
sv/sawt_pkg.sv
sv/sawt_ctrl.sv
sv/sawt_dp.sv
sv/selective_ack_window_tracker.sv
dv/tb_selective_ack_window_tracker.sv
